>>> design/bof_pkg.sv
// bof_pkg: shared types and constants of the bitset overlap filter
// no dependencies; used by the interfaces and all modules
package bof_pkg;

    localparam int IDX_W      = 12;
    localparam int IDX_SPAN   = 4096;
    localparam int WORD_W     = 64;
    localparam int PC_W       = 7;
    localparam int SUM_W      = 19;
    localparam int NUM_W      = 32;
    localparam int CUTOFF_W   = 17;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = CUTOFF_W + SUM_W;
    localparam int OUT_DEPTH  = 8;
    localparam int OUT_AW     = 3;
    localparam int CREDIT_W   = 4;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic CMD_LIBRARY = 1'b0;
    localparam logic CMD_SCORE   = 1'b1;

    // control word that follows one scored word down the pipeline
    typedef struct packed {
        logic valid;
        logic in_range;
        logic last;
    } t_stage_ctl;

    typedef struct packed {
        logic             passed;
        logic [NUM_W-1:0] spectrum_number;
        logic [SUM_W-1:0] shared_bits;
        logic [SUM_W-1:0] spectrum_bits;
    } t_result;

endpackage

>>> design/bof_in_if.sv
// bof_in_if: valid/ready channel carrying one command word
// depends on bof_pkg for field widths
interface bof_in_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [bof_pkg::IDX_W-1:0]   word_addr;
    logic [bof_pkg::WORD_W-1:0]  data_word;
    logic                        last_word;

    modport source (output valid, command, word_addr, data_word, last_word, input ready);
    modport sink   (input valid, command, word_addr, data_word, last_word, output ready);
endinterface

>>> design/bof_out_if.sv
// bof_out_if: valid/ready channel carrying one spectrum result
// depends on bof_pkg for field widths
interface bof_out_if;
    logic                       valid;
    logic                       ready;
    logic                       passed;
    logic [bof_pkg::NUM_W-1:0]  spectrum_number;
    logic [bof_pkg::SUM_W-1:0]  shared_bits;
    logic [bof_pkg::SUM_W-1:0]  spectrum_bits;

    modport source (output valid, passed, spectrum_number, shared_bits, spectrum_bits,
                    input ready);
    modport sink   (input valid, passed, spectrum_number, shared_bits, spectrum_bits,
                    output ready);
endinterface

>>> design/bof_lib_mem.sv
// bof_lib_mem: single-port library word memory, registered read data
// depends on bof_pkg for the word width
module bof_lib_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_addr,
    input  logic [bof_pkg::WORD_W-1:0]  i_wdata,
    output logic [bof_pkg::WORD_W-1:0]  o_rdata
);

    logic [bof_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [bof_pkg::WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/bof_score.sv
// bof_score: popcount, saturating accumulation and cutoff compare pipeline
// depends on bof_pkg; library word is registered and arrives in the cycle after the request
module bof_score (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bof_pkg::t_stage_ctl           i_ctl,
    input  logic [bof_pkg::WORD_W-1:0]    i_word,
    input  logic [bof_pkg::WORD_W-1:0]    i_lib_word,
    input  logic [bof_pkg::CUTOFF_W-1:0]  i_cutoff,
    output logic                          o_push,
    output bof_pkg::t_result              o_result
);

    // adder tree over the 64 bits of one word
    function automatic logic [bof_pkg::PC_W-1:0] count_ones(
        input logic [bof_pkg::WORD_W-1:0] v
    );
        logic [1:0] p2  [32];
        logic [2:0] p4  [16];
        logic [3:0] p8  [8];
        logic [4:0] p16 [4];
        logic [5:0] p32 [2];
        for (int k = 0; k < 32; k++) begin
            p2[k] = {1'b0, v[2*k]} + {1'b0, v[2*k+1]};
        end
        for (int k = 0; k < 16; k++) begin
            p4[k] = {1'b0, p2[2*k]} + {1'b0, p2[2*k+1]};
        end
        for (int k = 0; k < 8; k++) begin
            p8[k] = {1'b0, p4[2*k]} + {1'b0, p4[2*k+1]};
        end
        for (int k = 0; k < 4; k++) begin
            p16[k] = {1'b0, p8[2*k]} + {1'b0, p8[2*k+1]};
        end
        for (int k = 0; k < 2; k++) begin
            p32[k] = {1'b0, p16[2*k]} + {1'b0, p16[2*k+1]};
        end
        return {1'b0, p32[0]} + {1'b0, p32[1]};
    endfunction

    function automatic logic [bof_pkg::SUM_W-1:0] sat_add(
        input logic [bof_pkg::SUM_W-1:0] a,
        input logic [bof_pkg::PC_W-1:0]  b
    );
        logic [bof_pkg::SUM_W:0] s;
        s = {1'b0, a} + (bof_pkg::SUM_W+1)'(b);
        return s[bof_pkg::SUM_W] ? bof_pkg::SUM_MAX : s[bof_pkg::SUM_W-1:0];
    endfunction

    // stage 1: word waits for the library read
    bof_pkg::t_stage_ctl         r_s1_ctl;
    logic [bof_pkg::WORD_W-1:0]  r_s1_word;
    // stage 2: popcounts
    bof_pkg::t_stage_ctl         r_s2_ctl;
    logic [bof_pkg::PC_W-1:0]    r_s2_pc_spec;
    logic [bof_pkg::PC_W-1:0]    r_s2_pc_shared;
    // running sums
    logic [bof_pkg::SUM_W-1:0]   r_spec_sum;
    logic [bof_pkg::SUM_W-1:0]   r_shared_sum;
    logic [bof_pkg::NUM_W-1:0]   r_counter;
    // stage 3: finished sums
    logic                        r_s3_valid;
    logic [bof_pkg::SUM_W-1:0]   r_s3_spec;
    logic [bof_pkg::SUM_W-1:0]   r_s3_shared;
    logic [bof_pkg::NUM_W-1:0]   r_s3_num;
    // stage 4: product
    logic                        r_s4_valid;
    logic [bof_pkg::PROD_W-1:0]  r_s4_prod;
    logic [bof_pkg::SUM_W-1:0]   r_s4_spec;
    logic [bof_pkg::SUM_W-1:0]   r_s4_shared;
    logic [bof_pkg::NUM_W-1:0]   r_s4_num;

    logic [bof_pkg::PC_W-1:0]    n_pc_spec;
    logic [bof_pkg::PC_W-1:0]    n_pc_shared;
    logic [bof_pkg::SUM_W-1:0]   n_spec_sum;
    logic [bof_pkg::SUM_W-1:0]   n_shared_sum;
    logic [bof_pkg::PROD_W-1:0]  n_lhs;

    // out-of-range words add nothing
    always_comb begin
        n_pc_spec   = r_s1_ctl.in_range ? count_ones(r_s1_word) : '0;
        n_pc_shared = r_s1_ctl.in_range ? count_ones(r_s1_word & i_lib_word) : '0;
    end

    assign n_spec_sum   = sat_add(r_spec_sum, r_s2_pc_spec);
    assign n_shared_sum = sat_add(r_shared_sum, r_s2_pc_shared);
    assign n_lhs        = bof_pkg::PROD_W'({r_s4_shared, {bof_pkg::FRAC_BITS{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl     <= '0;
            r_s2_ctl     <= '0;
            r_spec_sum   <= '0;
            r_shared_sum <= '0;
            r_counter    <= '0;
            r_s3_valid   <= 1'b0;
            r_s4_valid   <= 1'b0;
        end else begin
            r_s1_ctl   <= i_ctl;
            r_s2_ctl   <= r_s1_ctl;
            r_s3_valid <= r_s2_ctl.valid && r_s2_ctl.last;
            r_s4_valid <= r_s3_valid;
            if (r_s2_ctl.valid) begin
                if (r_s2_ctl.last) begin
                    r_spec_sum   <= '0;
                    r_shared_sum <= '0;
                    r_counter    <= r_counter + bof_pkg::NUM_W'(1);
                end else begin
                    r_spec_sum   <= n_spec_sum;
                    r_shared_sum <= n_shared_sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_word      <= i_word;
        r_s2_pc_spec   <= n_pc_spec;
        r_s2_pc_shared <= n_pc_shared;
        r_s3_spec      <= n_spec_sum;
        r_s3_shared    <= n_shared_sum;
        r_s3_num       <= r_counter;
        r_s4_prod      <= bof_pkg::PROD_W'(i_cutoff) * bof_pkg::PROD_W'(r_s3_spec);
        r_s4_spec      <= r_s3_spec;
        r_s4_shared    <= r_s3_shared;
        r_s4_num       <= r_s3_num;
    end

    assign o_push                   = r_s4_valid;
    assign o_result.passed          = (r_s4_spec != '0) && (n_lhs > r_s4_prod);
    assign o_result.spectrum_number = r_s4_num;
    assign o_result.shared_bits     = r_s4_shared;
    assign o_result.spectrum_bits   = r_s4_spec;

endmodule

>>> design/bof_out_fifo.sv
// bof_out_fifo: small result queue between the score pipeline and the output channel
// depends on bof_pkg for the result type and depth
module bof_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bof_pkg::t_result  i_data,
    input  logic              i_pop,
    output logic              o_valid,
    output bof_pkg::t_result  o_data
);

    bof_pkg::t_result                 r_slot [bof_pkg::OUT_DEPTH];
    logic [bof_pkg::OUT_AW-1:0]       r_wr_ptr;
    logic [bof_pkg::OUT_AW-1:0]       r_rd_ptr;
    logic [bof_pkg::CREDIT_W-1:0]     r_count;
    logic                             n_pop;

    assign n_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + bof_pkg::OUT_AW'(1);
            end
            if (n_pop) begin
                r_rd_ptr <= r_rd_ptr + bof_pkg::OUT_AW'(1);
            end
            r_count <= r_count + bof_pkg::CREDIT_W'(i_push) - bof_pkg::CREDIT_W'(n_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];

endmodule

>>> design/bitset_overlap_filter_top.sv
// bitset_overlap_filter_top: top level of the bitset overlap coefficient filter
// depends on bof_pkg, bof_in_if, bof_out_if, bof_lib_mem, bof_score, bof_out_fifo
//
// Takes one word per cycle, library writes and scored words alike, as long as fewer than
// 8 spectrum results are outstanding (accepted but not yet transferred out); that limit is
// the depth of the result queue. A library write updates the single-port word memory in
// the cycle after its transfer, so a scored word may follow it immediately at the same
// index. After its last word is taken, a result goes through the library read at the
// transfer edge itself, then registered popcount, accumulation and cutoff multiply, and
// a combinational compare as it enters the queue; it can then transfer out. The cutoff
// register may only be written while no spectrum is in flight.
module bitset_overlap_filter_top #(
    parameter int BITSET_WORDS = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bof_pkg::CUTOFF_W-1:0]    i_cfg_data,
    bof_in_if.sink                          i_in,
    bof_out_if.source                       o_out
);

    localparam int MEM_DEPTH = (BITSET_WORDS < bof_pkg::IDX_SPAN) ? BITSET_WORDS
                                                                  : bof_pkg::IDX_SPAN;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    logic [bof_pkg::CUTOFF_W-1:0]  r_cutoff;
    logic [bof_pkg::CREDIT_W-1:0]  r_credit;

    logic                          n_accept;
    logic                          n_in_range;
    logic                          n_result_in;
    logic                          n_result_out;
    bof_pkg::t_stage_ctl           n_ctl;
    logic [bof_pkg::WORD_W-1:0]    n_lib_word;
    logic                          n_push;
    bof_pkg::t_result              n_push_data;
    bof_pkg::t_result              n_head;

    assign i_in.ready   = (r_credit != bof_pkg::CREDIT_W'(bof_pkg::OUT_DEPTH));
    assign n_accept     = i_in.valid && i_in.ready;
    assign n_in_range   = (int'(i_in.word_addr) < BITSET_WORDS);
    assign n_result_in  = n_accept && (i_in.command == bof_pkg::CMD_SCORE) && i_in.last_word;
    assign n_result_out = o_out.valid && o_out.ready;

    always_comb begin
        n_ctl.valid    = n_accept && (i_in.command == bof_pkg::CMD_SCORE);
        n_ctl.in_range = n_in_range;
        n_ctl.last     = i_in.last_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= '0;
            r_credit <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cutoff <= i_cfg_data;
            end
            // results promised to the queue, counted from transfer in to transfer out
            r_credit <= r_credit + bof_pkg::CREDIT_W'(n_result_in)
                                 - bof_pkg::CREDIT_W'(n_result_out);
        end
    end

    bof_lib_mem #(
        .DEPTH (MEM_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (n_accept && (i_in.command == bof_pkg::CMD_LIBRARY) && n_in_range),
        .i_re    (n_accept && (i_in.command == bof_pkg::CMD_SCORE)),
        .i_addr  (i_in.word_addr[AW-1:0]),
        .i_wdata (i_in.data_word),
        .o_rdata (n_lib_word)
    );

    bof_score u_score (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (n_ctl),
        .i_word     (i_in.data_word),
        .i_lib_word (n_lib_word),
        .i_cutoff   (r_cutoff),
        .o_push     (n_push),
        .o_result   (n_push_data)
    );

    bof_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (n_push),
        .i_data  (n_push_data),
        .i_pop   (o_out.ready),
        .o_valid (o_out.valid),
        .o_data  (n_head)
    );

    assign o_out.passed          = n_head.passed;
    assign o_out.spectrum_number = n_head.spectrum_number;
    assign o_out.shared_bits     = n_head.shared_bits;
    assign o_out.spectrum_bits   = n_head.spectrum_bits;

endmodule
